@@ rtl/frti_pkg.sv @@
// ----------------------------------------------------------------------------
// frti_pkg
// shared types and constants for the float round-to-integral pipeline
// ----------------------------------------------------------------------------
package frti_pkg;

   localparam logic [1:0] MODE_CEIL    = 2'd0;
   localparam logic [1:0] MODE_FLOOR   = 2'd1;
   localparam logic [1:0] MODE_TRUNC   = 2'd2;
   localparam logic [1:0] MODE_NEAREST = 2'd3;

   localparam int DATA_W = 64;

   // request packet: op, is_double, operand
   typedef struct packed {
      logic [1:0]        op;
      logic              is_double;
      logic [DATA_W-1:0] operand;
   } req_type;

   // decoded operand, normalized to a common 64-bit view
   typedef struct packed {
      logic              is_double;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] sign_bit;
      logic [DATA_W-1:0] one;
      logic              neg;
      logic              pass;
      logic              below_one;
      logic              near_half;
      logic [DATA_W-1:0] fmask;
      logic [5:0]        odd_pos;
      logic              e_zero;
      logic [1:0]        op;
   } dec_type;

   // rounding decision
   typedef struct packed {
      logic              is_double;
      logic [DATA_W-1:0] t;
      logic [DATA_W-1:0] unit;
      logic              up;
      logic              done;
      logic [DATA_W-1:0] fixed;
   } dcs_type;

endpackage

@@ rtl/frti_decode.sv @@
// ----------------------------------------------------------------------------
// frti_decode
// splits the operand into sign, exponent and fraction mask; flags special cases
// ----------------------------------------------------------------------------
module frti_decode (
   input  frti_pkg::req_type req,
   output frti_pkg::dec_type dec
);

   logic [10:0] exp;
   logic [10:0] emask;
   logic [10:0] bias;
   logic [5:0]  mbits;
   logic [10:0] e;
   logic [63:0] mmask;
   logic [63:0] x;
   logic [63:0] mag;

   always_comb begin
      if (req.is_double) begin
         x     = req.operand;
         exp   = req.operand[62:52];
         emask = 11'h7FF;
         bias  = 11'd1023;
         mbits = 6'd52;
         mmask = 64'h000F_FFFF_FFFF_FFFF;
         dec.sign_bit = 64'h8000_0000_0000_0000;
         dec.one      = 64'h3FF0_0000_0000_0000;
      end else begin
         x     = {32'd0, req.operand[31:0]};
         exp   = {3'd0, req.operand[30:23]};
         emask = 11'h0FF;
         bias  = 11'd127;
         mbits = 6'd23;
         mmask = 64'h0000_0000_007F_FFFF;
         dec.sign_bit = 64'h0000_0000_8000_0000;
         dec.one      = 64'h0000_0000_3F80_0000;
      end
      mag = x & ~dec.sign_bit;
      e   = exp - bias;
      dec.is_double = req.is_double;
      dec.x         = x;
      dec.op        = req.op;
      dec.neg       = (x & dec.sign_bit) != 64'd0;
      dec.pass      = (exp == emask) || (exp >= bias + {5'd0, mbits}) || (mag == 64'd0);
      dec.below_one = exp < bias;
      dec.near_half = (exp == bias - 11'd1) && ((x & mmask) != 64'd0);
      dec.fmask     = mmask >> e[5:0];
      dec.odd_pos   = mbits - e[5:0];
      dec.e_zero    = e == 11'd0;
   end

endmodule

@@ rtl/frti_decide.sv @@
// ----------------------------------------------------------------------------
// frti_decide
// picks the fixed result for special cases or the round-up decision
// ----------------------------------------------------------------------------
module frti_decide (
   input  frti_pkg::dec_type dec,
   output frti_pkg::dcs_type dcs
);

   logic [63:0] frac;
   logic [63:0] half;
   logic [63:0] szero;
   logic        odd;

   always_comb begin
      frac  = dec.x & dec.fmask;
      half  = (dec.fmask + 64'd1) >> 1;
      szero = dec.neg ? dec.sign_bit : 64'd0;
      odd   = dec.e_zero ? 1'b1 : dec.x[dec.odd_pos];
      dcs.is_double = dec.is_double;
      dcs.t    = dec.x & ~dec.fmask;
      dcs.unit = dec.fmask + 64'd1;
      dcs.up   = 1'b0;
      dcs.done = 1'b1;
      dcs.fixed = dec.x;
      if (dec.pass) begin
         dcs.fixed = dec.x;
      end else if (dec.below_one) begin
         unique case (dec.op)
            frti_pkg::MODE_CEIL:  dcs.fixed = dec.neg ? dec.sign_bit : dec.one;
            frti_pkg::MODE_FLOOR: dcs.fixed = dec.neg ? (dec.sign_bit | dec.one) : 64'd0;
            frti_pkg::MODE_TRUNC: dcs.fixed = szero;
            default:              dcs.fixed = dec.near_half ? (szero | dec.one) : szero;
         endcase
      end else if (frac == 64'd0) begin
         dcs.fixed = dec.x;
      end else begin
         dcs.done = 1'b0;
         unique case (dec.op)
            frti_pkg::MODE_CEIL:  dcs.up = !dec.neg;
            frti_pkg::MODE_FLOOR: dcs.up = dec.neg;
            frti_pkg::MODE_TRUNC: dcs.up = 1'b0;
            default:              dcs.up = (frac > half) || ((frac == half) && odd);
         endcase
      end
   end

endmodule

@@ rtl/float_round_to_integral.sv @@
// ----------------------------------------------------------------------------
// float_round_to_integral
// rounds a binary32 or binary64 value to an integral value (ceil, floor,
// trunc, nearest ties-even)
// ----------------------------------------------------------------------------
// Four register stages: input capture, decode, rounding decision, and the
// increment into the output register. One request is accepted every clock
// cycle while req_tready is high, and its result reaches rsp through the decode,
// decision and output registers; a stall on the rsp side holds every full stage
// without loss; req_tready stays high while any stage is empty or rsp_tready is high.
module float_round_to_integral (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // op[1:0], is_double[2], operand[66:3], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata   // rounded[63:0]
);

   frti_pkg::req_type req;
   frti_pkg::dec_type dec, dec_ff;
   frti_pkg::dcs_type dcs, dcs_ff;
   frti_pkg::req_type req_ff;
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic        en1, en2, en3, en4;
   logic [63:0] res_in, res_ff;

   assign en4 = !v4_ff || rsp_tready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   assign req.op        = req_tdata[1:0];
   assign req.is_double = req_tdata[2];
   assign req.operand   = req_tdata[66:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) req_ff <= req;
      if (en2) dec_ff <= dec;
      if (en3) dcs_ff <= dcs;
   end

   frti_decode u_decode (.req(req_ff), .dec(dec));
   frti_decide u_decide (.dec(dec_ff), .dcs(dcs));

   always_comb begin
      if (dcs_ff.done) begin
         res_in = dcs_ff.fixed;
      end else begin
         res_in = dcs_ff.up ? dcs_ff.t + dcs_ff.unit : dcs_ff.t;
      end
      if (!dcs_ff.is_double) res_in[63:32] = 32'd0;
   end

   // final output register
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) res_ff <= res_in;
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = res_ff;

endmodule

@@ bench/tb_float_round_to_integral.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_float_round_to_integral
// drives random and corner requests through the round-to-integral pipeline
// and checks each result against a bit-level predictor, under random idling
// on both sides of the stream
// ----------------------------------------------------------------------------

class rounding_scoreboard;
   logic [63:0] pending[$];
   int          errors = 0;

   static function logic [63:0] round_bits(logic [63:0] x, logic [1:0] mode,
                                           int width, int mbits, int ebits);
      logic [63:0] sign_bit, emask, mmask, bias, one, ex, mag, szero, fmask, unitv;
      logic [63:0] frac, t, half;
      logic        neg, up, odd;
      int          e;
      sign_bit = 64'd1 << (width - 1);
      emask = (64'd1 << ebits) - 1;
      mmask = (64'd1 << mbits) - 1;
      bias = emask >> 1;
      one = bias << mbits;
      neg = (x & sign_bit) != 0;
      ex = (x >> mbits) & emask;
      mag = x & ~sign_bit;
      szero = neg ? sign_bit : 64'd0;
      if (ex == emask || ex >= bias + mbits || mag == 0) return x;
      if (ex < bias) begin
         case (mode)
            frti_pkg::MODE_CEIL:  return neg ? sign_bit : one;
            frti_pkg::MODE_FLOOR: return neg ? (sign_bit | one) : 64'd0;
            frti_pkg::MODE_TRUNC: return szero;
            default: begin
               if (ex == bias - 1 && (x & mmask) != 0) return szero | one;
               return szero;
            end
         endcase
      end
      e = int'(ex - bias);
      fmask = mmask >> e;
      unitv = fmask + 1;
      frac = x & fmask;
      t = x & ~fmask;
      if (frac == 0) return x;
      case (mode)
         frti_pkg::MODE_CEIL:  up = !neg;
         frti_pkg::MODE_FLOOR: up = neg;
         frti_pkg::MODE_TRUNC: up = 1'b0;
         default: begin
            half = unitv >> 1;
            odd = (e == 0) ? 1'b1 : t[mbits - e];
            up = frac > half || (frac == half && odd);
         end
      endcase
      if (up) t = t + unitv;
      return t;
   endfunction

   function void note_request(logic [1:0] mode, logic dbl, logic [63:0] operand);
      logic [63:0] r;
      if (dbl) begin
         pending.push_back(round_bits(operand, mode, 64, 52, 11));
      end else begin
         r = round_bits({32'd0, operand[31:0]}, mode, 32, 23, 8);
         pending.push_back({32'd0, r[31:0]});
      end
   endfunction

   function void check_result(logic [63:0] got);
      logic [63:0] want;
      if (pending.size() == 0) begin
         $display("%0t unexpected result: expected none actual %h", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         $display("%0t rounded mismatch: expected %h actual %h", $time, want, got);
         errors++;
      end
   endfunction
endclass

module tb_float_round_to_integral;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   rounding_scoreboard board = new();
   int send_idle = 0;
   int recv_stall = 0;

   float_round_to_integral dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_request(req_tdata[1:0], req_tdata[2], req_tdata[66:3]);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic send(logic [1:0] mode, logic dbl, logic [63:0] operand);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, operand, dbl, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_idle_cycle();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // biased toward exponents near the integral boundary
   function automatic logic [63:0] pick_operand(logic dbl);
      logic [63:0] v;
      int          ex;
      v = {$urandom, $urandom};
      if ($urandom_range(9) < 8) begin
         if (dbl) begin
            ex = 1023 + $urandom_range(56) - 4;
            v[62:52] = ex[10:0];
            if ($urandom_range(3) == 0) v[51:0] = v[51:0] & ~(52'h3 << $urandom_range(50));
         end else begin
            ex = 127 + $urandom_range(27) - 3;
            v[30:23] = ex[7:0];
            if ($urandom_range(3) == 0) v[22:0] = v[22:0] & ~(23'h3 << $urandom_range(21));
         end
      end
      return v;
   endfunction

   initial begin
      logic [63:0] corners[$];
      logic [1:0]  m;
      int          ph;
      corners = '{64'h0, 64'h80000000, 64'h3F000000, 64'hBF000000, 64'h3FC00000,
                  64'h40200000, 64'hBFC00000, 64'h7FC00001, 64'hFF800000,
                  64'h4B000001, 64'h3F7FFFFF, 64'hFFFFFFFF_00000001};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      rsp_tready <= 1'b1;
      @(posedge clock);
      for (int i = 0; i < corners.size(); i++) begin
         m = i[1:0];
         send(m, 1'b0, corners[i]);
      end
      send(frti_pkg::MODE_NEAREST, 1'b1, 64'h3FE0000000000000);
      send(frti_pkg::MODE_NEAREST, 1'b1, 64'h4004000000000000);
      send(frti_pkg::MODE_CEIL, 1'b1, 64'hBFEFFFFFFFFFFFFF);
      send(frti_pkg::MODE_FLOOR, 1'b1, 64'hBFB0000000000000);
      send(frti_pkg::MODE_TRUNC, 1'b1, 64'h8000000000000000);
      send(frti_pkg::MODE_CEIL, 1'b1, 64'h433FFFFFFFFFFFFF);
      send(frti_pkg::MODE_NEAREST, 1'b1, 64'h7FF0000000000001);
      send(frti_pkg::MODE_FLOOR, 1'b1, 64'hFFFFFFFFFFFFFFFF);
      send(frti_pkg::MODE_CEIL, 1'b1, 64'h432FFFFFFFFFFFFF);
      for (ph = 0; ph < 4; ph++) begin
         send_idle  = (ph == 1) ? 45 : (ph == 3) ? 23 : 0;
         recv_stall = (ph == 2) ? 45 : (ph == 3) ? 23 : 0;
         for (int i = 0; i < 410; i++) begin
            m = 2'($urandom_range(3));
            send(m, 1'($urandom_range(1)), pick_operand(1'($urandom_range(1))));
         end
         // hold off until the pipeline has drained
         send_idle_cycle();
         while (board.pending.size() != 0) @(posedge clock);
      end
      send_idle_cycle();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #200000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/frti_pkg.sv
rtl/frti_decode.sv
rtl/frti_decide.sv
rtl/float_round_to_integral.sv
bench/tb_float_round_to_integral.sv
